@@ rtl/hti_pkg.sv @@
// Shared types and constants for the Hermite tension/bias interpolator.
// Holds payload structs, pipeline advance struct, register codes and widths.
// No dependencies.
package hti_pkg;

  // field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int POS_BITS     = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int CFG_ADDR_W   = 2;

  // fixed-point formats
  localparam int BASIS_BITS   = 24;                 // basis weights Q.24
  localparam int TANGENT_BITS = 4;                  // tangents Q.4
  localparam int TAN_SHIFT    = 29 - TANGENT_BITS;  // Q.29 slope down to Q.4
  localparam int SUM_SHIFT    = BASIS_BITS + TANGENT_BITS;
  localparam int UNIT_Q14     = 16384;

  // datapath widths
  localparam int DIFF_W   = SAMPLE_WIDTH + 1;
  localparam int WEIGHT_W = 32;                     // tangent weights <= 2^30
  localparam int PROD_W   = DIFF_W + WEIGHT_W;
  localparam int SLOPE_W  = PROD_W + 1;
  localparam int TAN_W    = SAMPLE_WIDTH + 7;
  localparam int U_W      = BASIS_BITS;
  localparam int UU_W     = 2 * U_W;
  localparam int U2_W     = BASIS_BITS + 1;
  localparam int U2U_W    = U2_W + U_W;
  localparam int U3_W     = BASIS_BITS + 2;
  localparam int BASIS_W  = BASIS_BITS + 4;
  localparam int YTERM_W  = BASIS_W + SAMPLE_WIDTH;
  localparam int TTERM_W  = BASIS_W + TAN_W;
  localparam int TOTAL_W  = TTERM_W + 2;
  localparam int ROUND_W  = TOTAL_W - SUM_SHIFT;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TENSION = 2'd0,
    REG_BIAS    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_before;
    logic signed [SAMPLE_WIDTH-1:0] sample_start;
    logic signed [SAMPLE_WIDTH-1:0] sample_end;
    logic signed [SAMPLE_WIDTH-1:0] sample_after;
    logic        [POS_BITS-1:0]     position;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           clipped;
  } result_t;

  // per-stage load strobes, stage 1 (input) to stage 7 (output register)
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } adv_t;

endpackage

@@ rtl/hti_tangent.sv @@
// Tangent path: weights from tension/bias, slopes m0/m1 in Q.4, stages 1 to 5.
// Also carries the two inner samples alongside. Depends on hti_pkg.
module hti_tangent
  import hti_pkg::*;
(
  input  logic                           clk,
  input  logic signed [CFG_WIDTH-1:0]    tension,
  input  logic signed [CFG_WIDTH-1:0]    bias,
  input  adv_t                           adv,
  input  logic signed [SAMPLE_WIDTH-1:0] y0,
  input  logic signed [SAMPLE_WIDTH-1:0] y1,
  input  logic signed [SAMPLE_WIDTH-1:0] y2,
  input  logic signed [SAMPLE_WIDTH-1:0] y3,
  output logic signed [TAN_W-1:0]        m0,
  output logic signed [TAN_W-1:0]        m1,
  output logic signed [SAMPLE_WIDTH-1:0] y1_out,
  output logic signed [SAMPLE_WIDTH-1:0] y2_out
);

  localparam logic signed [SLOPE_W-1:0] TAN_HALF = SLOPE_W'(1) << (TAN_SHIFT - 1);
  localparam logic signed [CFG_WIDTH:0] ONE = (CFG_WIDTH + 1)'(UNIT_Q14);

  logic signed [CFG_WIDTH:0]        one_plus_b;
  logic signed [CFG_WIDTH:0]        one_minus_b;
  logic signed [CFG_WIDTH:0]        one_minus_t;
  logic signed [2*CFG_WIDTH+1:0]    wl_full;
  logic signed [2*CFG_WIDTH+1:0]    wr_full;
  logic signed [WEIGHT_W-1:0]       weight_l;
  logic signed [WEIGHT_W-1:0]       weight_r;

  logic signed [DIFF_W-1:0]         d0, d1, d2;
  logic signed [SAMPLE_WIDTH-1:0]   y1_s1, y2_s1, y1_s2, y2_s2, y1_s3, y2_s3, y1_s4, y2_s4;
  logic signed [PROD_W-1:0]         pl0, pr0, pl1, pr1;
  logic signed [SLOPE_W-1:0]        slope0, slope1;
  logic signed [SLOPE_W-1:0]        shifted0, shifted1;
  logic signed [TAN_W-1:0]          m0_s3, m1_s3, m0_s4, m1_s4;

  // tension and bias are already clamped to [-1, 1]
  assign one_plus_b  = ONE + (CFG_WIDTH + 1)'(bias);
  assign one_minus_b = ONE - (CFG_WIDTH + 1)'(bias);
  assign one_minus_t = ONE - (CFG_WIDTH + 1)'(tension);
  assign wl_full     = one_plus_b * one_minus_t;
  assign wr_full     = one_minus_b * one_minus_t;

  always_ff @(posedge clk) begin
    weight_l <= wl_full[WEIGHT_W-1:0];
    weight_r <= wr_full[WEIGHT_W-1:0];
  end

  // stage 1: segment differences
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d0    <= DIFF_W'(y1) - DIFF_W'(y0);
      d1    <= DIFF_W'(y2) - DIFF_W'(y1);
      d2    <= DIFF_W'(y3) - DIFF_W'(y2);
      y1_s1 <= y1;
      y2_s1 <= y2;
    end
  end

  // stage 2: weighted differences
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pl0   <= PROD_W'(d0) * PROD_W'(weight_l);
      pr0   <= PROD_W'(d1) * PROD_W'(weight_r);
      pl1   <= PROD_W'(d1) * PROD_W'(weight_l);
      pr1   <= PROD_W'(d2) * PROD_W'(weight_r);
      y1_s2 <= y1_s1;
      y2_s2 <= y2_s1;
    end
  end

  // stage 3: Q.29 slope rounded to Q.4
  assign slope0   = SLOPE_W'(pl0) + SLOPE_W'(pr0) + TAN_HALF;
  assign slope1   = SLOPE_W'(pl1) + SLOPE_W'(pr1) + TAN_HALF;
  assign shifted0 = slope0 >>> TAN_SHIFT;
  assign shifted1 = slope1 >>> TAN_SHIFT;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      m0_s3 <= shifted0[TAN_W-1:0];
      m1_s3 <= shifted1[TAN_W-1:0];
      y1_s3 <= y1_s2;
      y2_s3 <= y2_s2;
    end
  end

  // stages 4 and 5: wait for the basis weights
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      m0_s4 <= m0_s3;
      m1_s4 <= m1_s3;
      y1_s4 <= y1_s3;
      y2_s4 <= y2_s3;
    end
    if (adv.s5) begin
      m0     <= m0_s4;
      m1     <= m1_s4;
      y1_out <= y1_s4;
      y2_out <= y2_s4;
    end
  end

endmodule

@@ rtl/hti_basis.sv @@
// Basis path: mu, mu^2, mu^3 and the four Hermite weights in Q.24, stages 1 to 5.
// Depends on hti_pkg.
module hti_basis
  import hti_pkg::*;
(
  input  logic                      clk,
  input  adv_t                      adv,
  input  logic [POS_BITS-1:0]       position,
  output logic signed [BASIS_W-1:0] h00,
  output logic signed [BASIS_W-1:0] h10,
  output logic signed [BASIS_W-1:0] h01,
  output logic signed [BASIS_W-1:0] h11
);

  localparam logic [UU_W:0]   HALF_UU  = (UU_W + 1)'(1) << (BASIS_BITS - 1);
  localparam logic [U2U_W:0]  HALF_U2U = (U2U_W + 1)'(1) << (BASIS_BITS - 1);
  localparam logic signed [BASIS_W-1:0] ONE = BASIS_W'(1) << BASIS_BITS;

  logic [U_W-1:0]    u_s1, u_s2, u_s3, u_s4;
  logic [UU_W-1:0]   uu;
  logic [UU_W:0]     uu_rnd;
  logic [U2_W-1:0]   u2_s3, u2_s4;
  logic [U2U_W-1:0]  u2u;
  logic [U2U_W:0]    u2u_rnd;
  logic signed [BASIS_W-1:0] su, su2, su3;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      u_s1 <= U_W'(position) << (BASIS_BITS - POS_BITS);
    end
    if (adv.s2) begin
      uu   <= UU_W'(u_s1) * UU_W'(u_s1);
      u_s2 <= u_s1;
    end
  end

  assign uu_rnd = (UU_W + 1)'(uu) + HALF_UU;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      u2_s3 <= uu_rnd[BASIS_BITS +: U2_W];
      u_s3  <= u_s2;
    end
    if (adv.s4) begin
      u2u   <= U2U_W'(u2_s3) * U2U_W'(u_s3);
      u2_s4 <= u2_s3;
      u_s4  <= u_s3;
    end
  end

  assign u2u_rnd = (U2U_W + 1)'(u2u) + HALF_U2U;
  assign su3     = $signed(BASIS_W'(u2u_rnd[BASIS_BITS +: U3_W]));
  assign su2     = $signed(BASIS_W'(u2_s4));
  assign su      = $signed(BASIS_W'(u_s4));

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      h00 <= (su3 <<< 1) - (su2 + (su2 <<< 1)) + ONE;
      h10 <= su3 - (su2 <<< 1) + su;
      h01 <= su3 - su2;
      h11 <= (su2 + (su2 <<< 1)) - (su3 <<< 1);
    end
  end

endmodule

@@ rtl/hti_combine.sv @@
// Weighted sum of samples and tangents, rounding and saturation, stages 6 and 7.
// Stage 7 is the output register. Depends on hti_pkg.
module hti_combine
  import hti_pkg::*;
(
  input  logic                           clk,
  input  adv_t                           adv,
  input  logic signed [BASIS_W-1:0]      h00,
  input  logic signed [BASIS_W-1:0]      h10,
  input  logic signed [BASIS_W-1:0]      h01,
  input  logic signed [BASIS_W-1:0]      h11,
  input  logic signed [TAN_W-1:0]        m0,
  input  logic signed [TAN_W-1:0]        m1,
  input  logic signed [SAMPLE_WIDTH-1:0] y1,
  input  logic signed [SAMPLE_WIDTH-1:0] y2,
  output result_t                        result
);

  localparam logic signed [TOTAL_W-1:0] SUM_HALF = TOTAL_W'(1) << (SUM_SHIFT - 1);
  localparam logic signed [ROUND_W-1:0] SMAX = (ROUND_W'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [ROUND_W-1:0] SMIN = -SMAX - 1;

  logic signed [YTERM_W-1:0] term_y1, term_y2;
  logic signed [TTERM_W-1:0] term_m0, term_m1;
  logic signed [TOTAL_W-1:0] ys, total, shifted;
  logic signed [ROUND_W-1:0] rounded;

  // stage 6: one product per term
  always_ff @(posedge clk) begin
    if (adv.s6) begin
      term_y1 <= YTERM_W'(h00) * YTERM_W'(y1);
      term_y2 <= YTERM_W'(h11) * YTERM_W'(y2);
      term_m0 <= TTERM_W'(h10) * TTERM_W'(m0);
      term_m1 <= TTERM_W'(h01) * TTERM_W'(m1);
    end
  end

  // stage 7: sum in Q.28, round to integer, saturate
  assign ys      = (TOTAL_W'(term_y1) + TOTAL_W'(term_y2)) <<< TANGENT_BITS;
  assign total   = ys + TOTAL_W'(term_m0) + TOTAL_W'(term_m1) + SUM_HALF;
  assign shifted = total >>> SUM_SHIFT;
  assign rounded = shifted[ROUND_W-1:0];

  always_ff @(posedge clk) begin
    if (adv.s7) begin
      if (rounded > SMAX) begin
        result.value   <= SMAX[SAMPLE_WIDTH-1:0];
        result.clipped <= 1'b1;
      end else if (rounded < SMIN) begin
        result.value   <= SMIN[SAMPLE_WIDTH-1:0];
        result.clipped <= 1'b1;
      end else begin
        result.value   <= rounded[SAMPLE_WIDTH-1:0];
        result.clipped <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/hermite_tension_bias_interpolator.sv @@
// Hermite cubic interpolator with tension/bias tangents: top level.
// Holds config registers and pipeline flow control. Depends on hti_pkg,
// hti_tangent, hti_basis and hti_combine.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample): four consecutive samples
//   and a Q0.16 position between the middle two. One transaction per cycle unless stalled.
//   result channel (result_valid/result_ready/result): interpolated value,
//   rounded and saturated, with the clipped flag. One result per transaction,
//   in order.
//   config port (cfg_en/cfg_addr/cfg_data): index 0 tension, 1 bias, signed
//   Q1.14; values beyond +/-1 are clamped on write, other indexes ignored.
//   Only write while the pipe is empty; the tangent weights are registered
//   and settle in the cycle after a write.
// Pipeline: seven register stages from sample acceptance to result_valid
//   (differences, weighted products, rounded tangents / mu^2, mu^3
//   product, basis weights, term products, sum and saturate).
// Throughput: one transaction per cycle through the seven-stage pipeline, unless it stalls.
// Stall: each stage holds its own valid bit and only stalls when it is full
//   and the one after it cannot move, so bubbles close up and sample_ready
//   stays high while the pipe has any empty stage behind a stalled result.
// Reset (rst, synchronous): empties the pipe, tension and bias return to 0.
module hermite_tension_bias_interpolator
  import hti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  localparam int STAGES = 7;
  localparam logic signed [CFG_WIDTH-1:0] CFG_MAX = CFG_WIDTH'(UNIT_Q14);
  localparam logic signed [CFG_WIDTH-1:0] CFG_MIN = -CFG_MAX;

  logic signed [CFG_WIDTH-1:0] tension;
  logic signed [CFG_WIDTH-1:0] bias;
  logic signed [CFG_WIDTH-1:0] cfg_clamped;

  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] stage_valid_next;
  logic [STAGES-1:0] stage_ready;
  logic [STAGES-1:0] load;
  adv_t              adv;

  logic signed [TAN_W-1:0]        m0, m1;
  logic signed [SAMPLE_WIDTH-1:0] y1, y2;
  logic signed [BASIS_W-1:0]      h00, h10, h01, h11;

  // config: clamp to [-1, 1] as it is written
  always_comb begin
    if ($signed(cfg_data) > CFG_MAX) begin
      cfg_clamped = CFG_MAX;
    end else if ($signed(cfg_data) < CFG_MIN) begin
      cfg_clamped = CFG_MIN;
    end else begin
      cfg_clamped = $signed(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= '0;
      bias    <= '0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_TENSION: tension <= cfg_clamped;
        REG_BIAS:    bias    <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // flow control: a stage takes new data when empty or when it drains
  always_comb begin
    stage_ready[STAGES-1] = !stage_valid[STAGES-1] || result_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
    load[0] = sample_valid && stage_ready[0];
    stage_valid_next[0] = stage_ready[0] ? sample_valid : stage_valid[0];
    for (int k = 1; k < STAGES; k++) begin
      load[k] = stage_valid[k-1] && stage_ready[k];
      stage_valid_next[k] = stage_ready[k] ? stage_valid[k-1] : stage_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign adv.s1 = load[0];
  assign adv.s2 = load[1];
  assign adv.s3 = load[2];
  assign adv.s4 = load[3];
  assign adv.s5 = load[4];
  assign adv.s6 = load[5];
  assign adv.s7 = load[6];

  assign sample_ready = stage_ready[0];
  assign result_valid = stage_valid[STAGES-1];

  hti_tangent u_tangent (
    .clk     (clk),
    .tension (tension),
    .bias    (bias),
    .adv     (adv),
    .y0      (sample.sample_before),
    .y1      (sample.sample_start),
    .y2      (sample.sample_end),
    .y3      (sample.sample_after),
    .m0      (m0),
    .m1      (m1),
    .y1_out  (y1),
    .y2_out  (y2)
  );

  hti_basis u_basis (
    .clk      (clk),
    .adv      (adv),
    .position (sample.position),
    .h00      (h00),
    .h10      (h10),
    .h01      (h01),
    .h11      (h11)
  );

  hti_combine u_combine (
    .clk    (clk),
    .adv    (adv),
    .h00    (h00),
    .h10    (h10),
    .h01    (h01),
    .h11    (h11),
    .m0     (m0),
    .m1     (m1),
    .y1     (y1),
    .y2     (y2),
    .result (result)
  );

endmodule
